// ----- design/kvtsv_pkg.sv -----
`timescale 1ns / 1ps

package kvtsv_pkg;

   localparam int COUNT_BITS_DEFAULT = 17;
   localparam int CAPACITY_BITS = 16;
   localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 16'd4096;

   // Error codes reported on the last byte of an image
   localparam logic [3:0] ERR_NONE       = 4'd0;
   localparam logic [3:0] ERR_CAPACITY   = 4'd1;
   localparam logic [3:0] ERR_HEADER     = 4'd2;
   localparam logic [3:0] ERR_EMPTY_LINE = 4'd3;
   localparam logic [3:0] ERR_NO_KEY     = 4'd4;
   localparam logic [3:0] ERR_KEY_CHAR   = 4'd5;
   localparam logic [3:0] ERR_HEX_CHAR   = 4'd6;
   localparam logic [3:0] ERR_HEX_ODD    = 4'd7;
   localparam logic [3:0] ERR_UNTERM     = 4'd8;

   localparam logic [7:0] CH_EQUAL    = 8'h3D;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;
   localparam logic [7:0] CH_DASH     = 8'h2D;
   localparam logic [7:0] CH_UNDER    = 8'h5F;

   localparam logic [2:0] HEADER_LEN = 3'd6;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_KEY    = 2'd1,
      PH_VALUE  = 2'd2,
      PH_STOP   = 2'd3
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } req_payload_type;

   typedef struct packed {
      logic       image_ok;
      logic [3:0] error_code;
   } rsp_payload_type;

   // Expected byte at each header position: "KVDB1\n"
   function automatic logic [7:0] header_byte(input logic [2:0] pos);
      logic [7:0] b;
      unique case (pos)
         3'd0:    b = 8'h4B;
         3'd1:    b = 8'h56;
         3'd2:    b = 8'h44;
         3'd3:    b = 8'h42;
         3'd4:    b = 8'h31;
         3'd5:    b = CH_NEWLINE;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic is_dec_char(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_key_char(input logic [7:0] c);
      return is_dec_char(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
             ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_DASH) || (c == CH_UNDER);
   endfunction

   function automatic logic is_hex_char(input logic [7:0] c);
      return is_dec_char(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
   endfunction

endpackage

// ----- design/kvtsv_parse.sv -----
`timescale 1ns / 1ps

module kvtsv_parse #(
   parameter int COUNT_BITS = kvtsv_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     step_en,
   input  kvtsv_pkg::req_payload_type               item,
   input  logic [kvtsv_pkg::CAPACITY_BITS-1:0]      capacity,
   output kvtsv_pkg::rsp_payload_type               result
);

   localparam int CMP_W = (COUNT_BITS > kvtsv_pkg::CAPACITY_BITS) ?
                          COUNT_BITS : kvtsv_pkg::CAPACITY_BITS;

   kvtsv_pkg::parse_phase_type phase_ff, phase_in;
   logic [2:0]            hdr_pos_ff, hdr_pos_in;
   logic                  key_nonempty_ff, key_nonempty_in;
   logic                  value_odd_ff, value_odd_in;
   logic [3:0]            first_error_ff, first_error_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] count_next;
   logic [CMP_W-1:0]      count_ext, capacity_ext;
   logic [3:0]            code;
   logic [7:0]            c;

   always_comb begin
      c          = item.data_byte;
      count_next = (count_ff != {COUNT_BITS{1'b1}}) ? count_ff + 1'b1 : count_ff;

      phase_in        = phase_ff;
      hdr_pos_in      = hdr_pos_ff;
      key_nonempty_in = key_nonempty_ff;
      value_odd_in    = value_odd_ff;
      first_error_in  = first_error_ff;

      unique case (phase_ff)
         kvtsv_pkg::PH_HEADER: begin
            if (hdr_pos_ff >= kvtsv_pkg::HEADER_LEN ||
                c != kvtsv_pkg::header_byte(hdr_pos_ff)) begin
               phase_in       = kvtsv_pkg::PH_STOP;
               first_error_in = kvtsv_pkg::ERR_HEADER;
            end else begin
               hdr_pos_in = hdr_pos_ff + 3'd1;
               if (hdr_pos_in == kvtsv_pkg::HEADER_LEN) begin
                  phase_in = kvtsv_pkg::PH_KEY;
               end
            end
         end
         kvtsv_pkg::PH_KEY: begin
            if (c == kvtsv_pkg::CH_NEWLINE) begin
               phase_in       = kvtsv_pkg::PH_STOP;
               first_error_in = key_nonempty_ff ? kvtsv_pkg::ERR_NO_KEY
                                                : kvtsv_pkg::ERR_EMPTY_LINE;
            end else if (c == kvtsv_pkg::CH_EQUAL) begin
               if (!key_nonempty_ff && first_error_ff == kvtsv_pkg::ERR_NONE) begin
                  first_error_in = kvtsv_pkg::ERR_NO_KEY;
               end
               phase_in = kvtsv_pkg::PH_VALUE;
            end else begin
               key_nonempty_in = 1'b1;
               if (!kvtsv_pkg::is_key_char(c) && first_error_ff == kvtsv_pkg::ERR_NONE) begin
                  first_error_in = kvtsv_pkg::ERR_KEY_CHAR;
               end
            end
         end
         kvtsv_pkg::PH_VALUE: begin
            if (c == kvtsv_pkg::CH_NEWLINE) begin
               if (first_error_ff != kvtsv_pkg::ERR_NONE) begin
                  phase_in = kvtsv_pkg::PH_STOP;
               end else if (value_odd_ff) begin
                  phase_in       = kvtsv_pkg::PH_STOP;
                  first_error_in = kvtsv_pkg::ERR_HEX_ODD;
               end else begin
                  phase_in        = kvtsv_pkg::PH_KEY;
                  key_nonempty_in = 1'b0;
                  value_odd_in    = 1'b0;
               end
            end else begin
               value_odd_in = ~value_odd_ff;
               if (!kvtsv_pkg::is_hex_char(c) && first_error_ff == kvtsv_pkg::ERR_NONE) begin
                  first_error_in = kvtsv_pkg::ERR_HEX_CHAR;
               end
            end
         end
         kvtsv_pkg::PH_STOP: begin
            // only the count advances
         end
         default: begin
            phase_in = kvtsv_pkg::PH_STOP;
         end
      endcase

      count_ext    = CMP_W'(count_next);
      capacity_ext = CMP_W'(capacity);
      if (count_ext > capacity_ext) begin
         code = kvtsv_pkg::ERR_CAPACITY;
      end else if (phase_in == kvtsv_pkg::PH_STOP) begin
         code = first_error_in;
      end else if (phase_in == kvtsv_pkg::PH_HEADER) begin
         code = kvtsv_pkg::ERR_HEADER;
      end else if (phase_in == kvtsv_pkg::PH_KEY && !key_nonempty_in) begin
         code = kvtsv_pkg::ERR_NONE;
      end else begin
         code = kvtsv_pkg::ERR_UNTERM;
      end
      result.image_ok   = (code == kvtsv_pkg::ERR_NONE);
      result.error_code = code;

      count_in = count_next;
      // rearm for the next image
      if (item.is_last) begin
         phase_in        = kvtsv_pkg::PH_HEADER;
         hdr_pos_in      = 3'd0;
         key_nonempty_in = 1'b0;
         value_odd_in    = 1'b0;
         first_error_in  = kvtsv_pkg::ERR_NONE;
         count_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= kvtsv_pkg::PH_HEADER;
         hdr_pos_ff      <= 3'd0;
         key_nonempty_ff <= 1'b0;
         value_odd_ff    <= 1'b0;
         first_error_ff  <= kvtsv_pkg::ERR_NONE;
         count_ff        <= '0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         hdr_pos_ff      <= hdr_pos_in;
         key_nonempty_ff <= key_nonempty_in;
         value_odd_ff    <= value_odd_in;
         first_error_ff  <= first_error_in;
         count_ff        <= count_in;
      end
   end

endmodule

// ----- design/keyvalue_text_store_validator_top.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall req_payload (data_byte, is_last)
// rsp       out        rsp_valid/rsp_stall rsp_payload (image_ok, error_code)
// csr       in         csr_wr_en           csr_wr_data (buffer_capacity)
//
// One byte per cycle sustained while the result register is not stalled.
// Each byte is held in the input register, then the parser updates its state
// and, on the last byte, loads the result register that drives rsp_payload.
// Synchronous active-high reset clears parse state and sets capacity to 4096.
// A stalled result holds the input register; req_stall rises only then.

module keyvalue_text_store_validator_top #(
   parameter int COUNT_BITS = kvtsv_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  kvtsv_pkg::req_payload_type          req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output kvtsv_pkg::rsp_payload_type          rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [kvtsv_pkg::CAPACITY_BITS-1:0] csr_wr_data
);

   logic                                in_valid_ff;
   kvtsv_pkg::req_payload_type          in_item_ff;
   logic                                rsp_valid_ff;
   kvtsv_pkg::rsp_payload_type          rsp_payload_ff;
   logic [kvtsv_pkg::CAPACITY_BITS-1:0] capacity_ff;
   kvtsv_pkg::rsp_payload_type          result;
   logic                                out_free;
   logic                                step_en;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   kvtsv_parse #(
      .COUNT_BITS(COUNT_BITS)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .item     (in_item_ff),
      .capacity (capacity_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= kvtsv_pkg::CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= req_payload;
      end
   end

   // advance the result register whenever it is free
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff && in_item_ff.is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && in_item_ff.is_last) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- verif/keyvalue_text_store_validator_top_tb.sv -----
`timescale 1ns / 1ps

module keyvalue_text_store_validator_top_tb;

   localparam int CNT_BITS = kvtsv_pkg::COUNT_BITS_DEFAULT;
   localparam logic [47:0] HEADER_TEXT = {"KVDB1", kvtsv_pkg::CH_NEWLINE};
   localparam int RANDOM_BYTES = 1500;
   localparam int MAX_REPORTS = 10;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   kvtsv_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   kvtsv_pkg::rsp_payload_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [kvtsv_pkg::CAPACITY_BITS-1:0] csr_wr_data = '0;

   keyvalue_text_store_validator_top #(
      .COUNT_BITS(CNT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Parser state mirrored from the block
   kvtsv_pkg::parse_phase_type kv_phase = kvtsv_pkg::PH_HEADER;
   logic [2:0] hdr_pos = '0;
   logic key_seen = 1'b0;
   logic val_odd = 1'b0;
   logic [3:0] line_err = kvtsv_pkg::ERR_NONE;
   logic [CNT_BITS-1:0] byte_total = '0;
   logic [kvtsv_pkg::CAPACITY_BITS-1:0] capacity_model = kvtsv_pkg::CAPACITY_RESET;

   kvtsv_pkg::req_payload_type pending_items[$];
   kvtsv_pkg::rsp_payload_type expected_reports[$];
   logic [7:0] image_bytes[$];
   int random_bytes = 0;
   int fail_count = 0;

   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("** keyvalue_text_store_validator_top: FAILED **");
      $finish;
   end

   function automatic logic is_name_byte(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == kvtsv_pkg::CH_DASH ||
             c == kvtsv_pkg::CH_UNDER;
   endfunction

   function automatic logic is_hex_byte(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
             (c >= "A" && c <= "F");
   endfunction

   task automatic clear_parser();
      kv_phase = kvtsv_pkg::PH_HEADER;
      hdr_pos = '0;
      key_seen = 1'b0;
      val_odd = 1'b0;
      line_err = kvtsv_pkg::ERR_NONE;
      byte_total = '0;
   endtask

   task automatic stop_parser(input logic [3:0] code);
      line_err = code;
      kv_phase = kvtsv_pkg::PH_STOP;
   endtask

   task automatic hold_line_err(input logic [3:0] code);
      if (line_err == kvtsv_pkg::ERR_NONE) line_err = code;
   endtask

   task automatic parse_char(input logic [7:0] c);
      case (kv_phase)
         kvtsv_pkg::PH_HEADER: begin
            if (hdr_pos >= kvtsv_pkg::HEADER_LEN ||
                c != HEADER_TEXT[8*(5 - hdr_pos) +: 8]) begin
               stop_parser(kvtsv_pkg::ERR_HEADER);
            end else begin
               hdr_pos = hdr_pos + 1'b1;
               if (hdr_pos == kvtsv_pkg::HEADER_LEN) kv_phase = kvtsv_pkg::PH_KEY;
            end
         end
         kvtsv_pkg::PH_KEY: begin
            if (c == kvtsv_pkg::CH_NEWLINE) begin
               stop_parser(key_seen ? kvtsv_pkg::ERR_NO_KEY : kvtsv_pkg::ERR_EMPTY_LINE);
            end else if (c == kvtsv_pkg::CH_EQUAL) begin
               if (!key_seen) hold_line_err(kvtsv_pkg::ERR_NO_KEY);
               kv_phase = kvtsv_pkg::PH_VALUE;
            end else begin
               key_seen = 1'b1;
               if (!is_name_byte(c)) hold_line_err(kvtsv_pkg::ERR_KEY_CHAR);
            end
         end
         kvtsv_pkg::PH_VALUE: begin
            if (c == kvtsv_pkg::CH_NEWLINE) begin
               if (line_err != kvtsv_pkg::ERR_NONE) begin
                  stop_parser(line_err);
               end else if (val_odd) begin
                  stop_parser(kvtsv_pkg::ERR_HEX_ODD);
               end else begin
                  kv_phase = kvtsv_pkg::PH_KEY;
                  key_seen = 1'b0;
                  val_odd = 1'b0;
               end
            end else begin
               val_odd = ~val_odd;
               if (!is_hex_byte(c)) hold_line_err(kvtsv_pkg::ERR_HEX_CHAR);
            end
         end
         default: ;
      endcase
   endtask

   task automatic predict_verdict(input kvtsv_pkg::req_payload_type item);
      logic [3:0] code;
      kvtsv_pkg::rsp_payload_type verdict;
      if (byte_total != {CNT_BITS{1'b1}}) byte_total = byte_total + 1'b1;
      parse_char(item.data_byte);
      if (item.is_last) begin
         if (byte_total > capacity_model) code = kvtsv_pkg::ERR_CAPACITY;
         else if (kv_phase == kvtsv_pkg::PH_STOP) code = line_err;
         else if (kv_phase == kvtsv_pkg::PH_HEADER) code = kvtsv_pkg::ERR_HEADER;
         else if (kv_phase == kvtsv_pkg::PH_KEY && !key_seen) code = kvtsv_pkg::ERR_NONE;
         else code = kvtsv_pkg::ERR_UNTERM;
         verdict.image_ok = (code == kvtsv_pkg::ERR_NONE);
         verdict.error_code = code;
         expected_reports.push_back(verdict);
         clear_parser();
      end
   endtask

   // Driver: bursts of items with random gaps; a stalled item holds
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
         burst_left = 0;
         gap_left = 0;
         clear_parser();
      end else begin
         if (req_valid && !req_stall) predict_verdict(req_payload);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_payload <= pending_items.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 32);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted verdict, stall in modes of varying length
   always @(posedge clock) begin
      kvtsv_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode = 0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected verdict: ok=%0d code=%0d",
                           rsp_payload.image_ok, rsp_payload.error_code);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_payload.image_ok !== want.image_ok ||
                   rsp_payload.error_code !== want.error_code) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("verdict mismatch: expected ok=%0d code=%0d, got ok=%0d code=%0d",
                              want.image_ok, want.error_code,
                              rsp_payload.image_ok, rsp_payload.error_code);
               end
            end
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // Sample at the falling edge so the driver's updates have settled
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_reports.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [kvtsv_pkg::CAPACITY_BITS-1:0] cap);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      capacity_model = cap;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 16'($urandom);
      @(posedge clock);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) image_bytes.push_back(s[i]);
   endtask

   function automatic logic [7:0] rand_name_byte();
      int r;
      r = $urandom_range(0, 63);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r < 62) return 8'("0" + r - 52);
      return (r == 62) ? kvtsv_pkg::CH_DASH : kvtsv_pkg::CH_UNDER;
   endfunction

   function automatic logic [7:0] rand_hex_byte();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) return 8'("0" + r);
      if (r < 16) return 8'("a" + r - 10);
      return 8'("A" + r - 16);
   endfunction

   function automatic logic [7:0] rand_odd_byte();
      case ($urandom_range(0, 5))
         0: return 8'($urandom);
         1: return kvtsv_pkg::CH_EQUAL;
         2: return kvtsv_pkg::CH_NEWLINE;
         3: return rand_name_byte();
         4: return rand_hex_byte();
         default: return {1'b1, 7'($urandom)};
      endcase
   endfunction

   task automatic add_good_line();
      int klen, pairs;
      klen = $urandom_range(1, 8);
      pairs = $urandom_range(0, 5);
      repeat (klen) image_bytes.push_back(rand_name_byte());
      image_bytes.push_back(kvtsv_pkg::CH_EQUAL);
      repeat (2 * pairs) image_bytes.push_back(rand_hex_byte());
      image_bytes.push_back(kvtsv_pkg::CH_NEWLINE);
   endtask

   // Queue the image, flag its final byte as last
   task automatic send_image();
      kvtsv_pkg::req_payload_type item;
      for (int i = 0; i < image_bytes.size(); i++) begin
         item.data_byte = image_bytes[i];
         item.is_last = (i == image_bytes.size() - 1);
         pending_items.push_back(item);
      end
      random_bytes += image_bytes.size();
      image_bytes.delete();
   endtask

   task automatic damage_image();
      int p;
      p = $urandom_range(0, image_bytes.size() - 1);
      case ($urandom_range(0, 4))
         0: image_bytes[p] = rand_odd_byte();
         1: image_bytes.insert(p, rand_odd_byte());
         2: if (image_bytes.size() > 1) image_bytes.delete(p);
         3: while (image_bytes.size() > p + 1) void'(image_bytes.pop_back());
         default: repeat ($urandom_range(1, 4)) image_bytes.push_back(rand_odd_byte());
      endcase
   endtask

   task automatic gen_random_image();
      int kind, plen;
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
         plen = $urandom_range(0, 5);
         for (int i = 0; i < plen; i++) image_bytes.push_back(HEADER_TEXT[8*(5 - i) +: 8]);
         repeat ($urandom_range(1, 10)) image_bytes.push_back(8'($urandom));
      end else begin
         add_text("KVDB1\n");
         repeat ($urandom_range(0, 4)) add_good_line();
         if (kind >= 6) repeat ($urandom_range(1, 2)) damage_image();
      end
      send_image();
   endtask

   initial begin
      int phase_end;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed images at the reset capacity
      add_text("KVDB1\n"); send_image();
      add_text("KVDB1\nazAZ09-_=0189afAF\nk=\n"); send_image();
      add_text("K"); send_image();
      add_text("KVDB2\n"); send_image();
      add_text("KVDB1\n\nzzzz"); send_image();
      add_text("KVDB1\n=12\n"); send_image();
      add_text("KVDB1\nab\n"); send_image();
      add_text("KVDB1\na.b=12\n"); send_image();
      add_text("KVDB1\na=1g\n"); send_image();
      add_text("KVDB1\na=123\n"); send_image();
      add_text("KVDB1\na=12"); send_image();
      add_text("KVDB1\nab"); send_image();
      add_text("KVDB1\na==\n"); send_image();
      add_text("KVDB1\n.=z\n"); send_image();
      add_text("KVDB1\na=1\nb.=zz\n"); send_image();
      add_text("KVDB1\na="); image_bytes.push_back(8'hFF); add_text("\n"); send_image();
      image_bytes.push_back(8'h00); send_image();

      set_capacity(16'd0);
      add_text("KVDB1\n"); send_image();
      add_text("X"); send_image();

      set_capacity(16'd6);
      add_text("KVDB1\n"); send_image();
      add_text("KVDB1\nk"); send_image();

      // Capacity boundary: one image that fits exactly, one a byte over
      set_capacity(16'd26);
      add_text("KVDB1\n");
      repeat (4) add_text("k=00\n");
      send_image();
      add_text("KVDB1\n");
      repeat (4) add_text("k=00\n");
      add_text("\n");
      send_image();

      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         case ($urandom_range(0, 4))
            0: set_capacity(16'($urandom_range(0, 40)));
            1: set_capacity(16'($urandom_range(20, 80)));
            2: set_capacity(16'($urandom));
            3: set_capacity(kvtsv_pkg::CAPACITY_RESET);
            default: set_capacity(16'hFFFF);
         endcase
         phase_end = random_bytes + $urandom_range(150, 350);
         while (random_bytes < phase_end) gen_random_image();
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_reports.size() == 0) begin
         $display("** keyvalue_text_store_validator_top: PASSED **");
      end else begin
         $display("** keyvalue_text_store_validator_top: FAILED **");
      end
      $finish;
   end

endmodule
